### rtl/four_function_calculator_core_defines.svh
// ----------------------------------------------------------------------------
// four function calculator core: assertion macros
// shared property forms for the calculator core checks
// ----------------------------------------------------------------------------
`ifndef FOUR_FUNCTION_CALCULATOR_CORE_DEFINES_SVH
`define FOUR_FUNCTION_CALCULATOR_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define FFC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define FFC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ffc_pkg.sv
// ----------------------------------------------------------------------------
// ffc_pkg
// types, microcode layout and constant tables of the calculator core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffc_pkg;

  typedef logic [4:0] upc_t;

  typedef enum logic [2:0] {
    ACT_DIGIT  = 3'd0,
    ACT_OPER   = 3'd1,
    ACT_EQUALS = 3'd2,
    ACT_NEGATE = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_e_t;

  typedef enum logic [2:0] {
    PEND_NONE = 3'd0,
    PEND_ADD  = 3'd1,
    PEND_SUB  = 3'd2,
    PEND_MUL  = 3'd3,
    PEND_DIV  = 3'd4
  } pend_t;

  // datapath operations, one per control word
  typedef enum logic [4:0] {
    U_NOP,
    U_DISPATCH,
    U_MUL10,
    U_APPEND,
    U_LOAD_DIGIT,
    U_TOTAL_ENTRY,
    U_ADDSUB,
    U_MUL,
    U_TOTAL_PROD,
    U_DIV_INIT,
    U_DIV_STEP,
    U_DIV_END,
    U_SHOW,
    U_NEGATE,
    U_LEN_INIT,
    U_LEN_STEP,
    U_LEN_END,
    U_EMIT,
    U_CLEAR
  } uop_t;

  // jump conditions
  typedef enum logic [3:0] {
    J_NONE,
    J_ALWAYS,
    J_DISPATCH,
    J_BAD_DIGIT,
    J_LOAD_DIGIT,
    J_AT_LIMIT,
    J_NO_APPLY,
    J_PEND_NONE,
    J_MUL,
    J_DIV,
    J_DIV_BUSY,
    J_LEN_MORE,
    J_OUT_BUSY
  } cond_t;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    upc_t  target;
  } ctrl_word_t;

  // routine entry points and jump targets
  localparam upc_t A_IDLE       = 5'd0;
  localparam upc_t A_DIGIT      = 5'd1;
  localparam upc_t A_DIG_LOAD   = 5'd6;
  localparam upc_t A_OPER       = 5'd7;
  localparam upc_t A_OPER_TOTAL = 5'd9;
  localparam upc_t A_EQUALS     = 5'd10;
  localparam upc_t A_APPLY      = 5'd11;
  localparam upc_t A_APPLY_MUL  = 5'd14;
  localparam upc_t A_APPLY_DIV  = 5'd16;
  localparam upc_t A_DIV_LOOP   = 5'd17;
  localparam upc_t A_FINISH     = 5'd19;
  localparam upc_t A_NEGATE     = 5'd20;
  localparam upc_t A_LEN        = 5'd21;
  localparam upc_t A_LEN_LOOP   = 5'd22;
  localparam upc_t A_DONE       = 5'd24;
  localparam upc_t A_CLEAR      = 5'd26;
  localparam upc_t A_LAST       = 5'd26;

  localparam logic [5:0] DivSteps = 6'd32;

  function automatic ctrl_word_t cw(input uop_t op, input cond_t cond, input upc_t target);
    ctrl_word_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // control store
  function automatic ctrl_word_t ucode(input upc_t a);
    ctrl_word_t w;
    case (a)
      A_IDLE:              w = cw(U_DISPATCH,    J_DISPATCH,   A_IDLE);
      A_DIGIT:             w = cw(U_NOP,         J_BAD_DIGIT,  A_DONE);
      A_DIGIT + 5'd1:      w = cw(U_NOP,         J_LOAD_DIGIT, A_DIG_LOAD);
      A_DIGIT + 5'd2:      w = cw(U_NOP,         J_AT_LIMIT,   A_DONE);
      A_DIGIT + 5'd3:      w = cw(U_MUL10,       J_NONE,       A_IDLE);
      A_DIGIT + 5'd4:      w = cw(U_APPEND,      J_ALWAYS,     A_DONE);
      A_DIG_LOAD:          w = cw(U_LOAD_DIGIT,  J_ALWAYS,     A_DONE);
      A_OPER:              w = cw(U_NOP,         J_NO_APPLY,   A_OPER_TOTAL);
      A_OPER + 5'd1:       w = cw(U_NOP,         J_ALWAYS,     A_APPLY);
      A_OPER_TOTAL:        w = cw(U_TOTAL_ENTRY, J_ALWAYS,     A_FINISH);
      A_EQUALS:            w = cw(U_NOP,         J_PEND_NONE,  A_DONE);
      A_APPLY:             w = cw(U_NOP,         J_MUL,        A_APPLY_MUL);
      A_APPLY + 5'd1:      w = cw(U_NOP,         J_DIV,        A_APPLY_DIV);
      A_APPLY + 5'd2:      w = cw(U_ADDSUB,      J_ALWAYS,     A_FINISH);
      A_APPLY_MUL:         w = cw(U_MUL,         J_NONE,       A_IDLE);
      A_APPLY_MUL + 5'd1:  w = cw(U_TOTAL_PROD,  J_ALWAYS,     A_FINISH);
      A_APPLY_DIV:         w = cw(U_DIV_INIT,    J_NONE,       A_IDLE);
      A_DIV_LOOP:          w = cw(U_DIV_STEP,    J_DIV_BUSY,   A_DIV_LOOP);
      A_DIV_LOOP + 5'd1:   w = cw(U_DIV_END,     J_NONE,       A_IDLE);
      A_FINISH:            w = cw(U_SHOW,        J_ALWAYS,     A_LEN);
      A_NEGATE:            w = cw(U_NEGATE,      J_NONE,       A_IDLE);
      A_LEN:               w = cw(U_LEN_INIT,    J_NONE,       A_IDLE);
      A_LEN_LOOP:          w = cw(U_LEN_STEP,    J_LEN_MORE,   A_LEN_LOOP);
      A_LEN_LOOP + 5'd1:   w = cw(U_LEN_END,     J_NONE,       A_IDLE);
      A_DONE:              w = cw(U_EMIT,        J_OUT_BUSY,   A_DONE);
      A_DONE + 5'd1:       w = cw(U_NOP,         J_ALWAYS,     A_IDLE);
      A_CLEAR:             w = cw(U_CLEAR,       J_ALWAYS,     A_DONE);
      default:             w = cw(U_NOP,         J_ALWAYS,     A_IDLE);
    endcase
    return w;
  endfunction

  // entry point of each key routine
  function automatic upc_t start_addr(input logic [2:0] action);
    upc_t a;
    case (action)
      ACT_DIGIT:  a = A_DIGIT;
      ACT_OPER:   a = A_OPER;
      ACT_EQUALS: a = A_EQUALS;
      ACT_NEGATE: a = A_NEGATE;
      ACT_CLEAR:  a = A_CLEAR;
      default:    a = A_DONE;
    endcase
    return a;
  endfunction

  // powers of ten for the length count, all ones past the ninth
  function automatic logic [31:0] pow10(input logic [3:0] k);
    logic [31:0] p;
    case (k)
      4'd0:    p = 32'd1;
      4'd1:    p = 32'd10;
      4'd2:    p = 32'd100;
      4'd3:    p = 32'd1000;
      4'd4:    p = 32'd10000;
      4'd5:    p = 32'd100000;
      4'd6:    p = 32'd1000000;
      4'd7:    p = 32'd10000000;
      4'd8:    p = 32'd100000000;
      4'd9:    p = 32'd1000000000;
      default: p = 32'hFFFF_FFFF;
    endcase
    return p;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

`default_nettype wire

### rtl/ffc_req_if.sv
// ----------------------------------------------------------------------------
// ffc_req_if
// key action request channel: valid, ready and the key fields
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ffc_req_if ();
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [3:0] digit_value;
  logic [1:0] operator_code;

  modport source (output valid, action, digit_value, operator_code, input ready);
  modport sink   (input valid, action, digit_value, operator_code, output ready);
endinterface

`default_nettype wire

### rtl/ffc_rsp_if.sv
// ----------------------------------------------------------------------------
// ffc_rsp_if
// display result channel: valid, ready and the display fields
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ffc_rsp_if ();
  logic               valid;
  logic               ready;
  logic signed [31:0] shown_value;
  logic        [4:0]  shown_chars;
  logic        [2:0]  operator_pending;
  logic               entry_is_fresh;

  modport source (output valid, shown_value, shown_chars, operator_pending, entry_is_fresh,
                  input ready);
  modport sink   (input valid, shown_value, shown_chars, operator_pending, entry_is_fresh,
                  output ready);
endinterface

`default_nettype wire

### rtl/four_function_calculator_core.sv
// ----------------------------------------------------------------------------
// four_function_calculator_core
// keypad logic of a 32-bit integer calculator run by a microcoded sequencer
// ----------------------------------------------------------------------------
// One key request is taken at a time and answered with exactly one display
// result. Operator, equals and negate run the selected arithmetic and then a
// decimal length count that loops once per result digit; divide uses the
// one-bit-per-cycle restoring divider (32 steps). A new request is taken once
// the previous result has been loaded into the output register; that register
// holds it until the sink takes it, and the next result waits in its routine
// while the previous one is still held.
`timescale 1ns / 1ps
`default_nettype none

`include "four_function_calculator_core_defines.svh"

module four_function_calculator_core import ffc_pkg::*; #(
  parameter int MAX_CHARS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  ffc_req_if.sink   req,
  ffc_rsp_if.source rsp
);

  localparam logic [4:0] MaxChars = 5'(MAX_CHARS);

  // sequencer
  upc_t       upc;
  upc_t       upc_next;
  ctrl_word_t word;
  logic       jump;

  // architectural state
  logic [31:0] entry;
  logic [4:0]  chars;
  logic [31:0] total;
  pend_t       pend;
  logic        fresh;

  // latched request
  logic [3:0] dig;
  logic [1:0] opc;
  logic       is_eq;

  // work registers
  logic [31:0] prod;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] mul_res;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic        div_neg;
  logic [5:0]  div_cnt;
  logic [32:0] div_shift;
  logic [32:0] div_diff;
  logic [31:0] len_mag;
  logic [3:0]  len_k;
  logic        len_more;

  // output register
  logic        out_valid;
  logic [31:0] out_value;
  logic [4:0]  out_chars;
  logic [2:0]  out_pend;
  logic        out_fresh;
  logic        out_busy;

  assign word      = ucode(upc);
  assign out_busy  = out_valid && !rsp.ready;
  assign req.ready = (word.cond == J_DISPATCH) && !rst;

  assign len_more  = (len_mag >= pow10(len_k));
  assign div_shift = {rem, quo[31]};
  assign div_diff  = div_shift - {1'b0, dvs};

  // one shared 32x32 multiplier, low half kept
  assign mul_a   = (word.op == U_MUL) ? total : entry;
  assign mul_b   = (word.op == U_MUL) ? entry : 32'd10;
  assign mul_res = mul_a * mul_b;

  always_comb begin
    case (word.cond)
      J_NONE:       jump = 1'b0;
      J_ALWAYS:     jump = 1'b1;
      J_DISPATCH:   jump = req.valid;
      J_BAD_DIGIT:  jump = (dig > 4'd9);
      J_LOAD_DIGIT: jump = fresh || (chars == 5'd1 && entry == 32'd0);
      J_AT_LIMIT:   jump = (chars >= MaxChars);
      J_NO_APPLY:   jump = (pend == PEND_NONE) || fresh;
      J_PEND_NONE:  jump = (pend == PEND_NONE);
      J_MUL:        jump = (pend == PEND_MUL);
      J_DIV:        jump = (pend == PEND_DIV);
      J_DIV_BUSY:   jump = (div_cnt != 6'd1);
      J_LEN_MORE:   jump = len_more;
      J_OUT_BUSY:   jump = out_busy;
      default:      jump = 1'b0;
    endcase
  end

  always_comb begin
    if (word.cond == J_DISPATCH) begin
      upc_next = req.valid ? start_addr(req.action) : upc;
    end else if (jump) begin
      upc_next = word.target;
    end else begin
      upc_next = upc + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= A_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  // datapath with reset state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= 32'd0;
      chars <= 5'd1;
      total <= 32'd0;
      pend  <= PEND_NONE;
      fresh <= 1'b1;
    end else begin
      case (word.op)
        U_APPEND: begin
          entry <= entry[31] ? (prod - {28'd0, dig}) : (prod + {28'd0, dig});
          chars <= chars + 5'd1;
        end
        U_LOAD_DIGIT: begin
          entry <= {28'd0, dig};
          chars <= 5'd1;
          fresh <= 1'b0;
        end
        U_TOTAL_ENTRY: total <= entry;
        U_ADDSUB:      total <= (pend == PEND_SUB) ? (total - entry) : (total + entry);
        U_TOTAL_PROD:  total <= prod;
        U_DIV_END: begin
          if (entry == 32'd0) begin
            total <= 32'd0;
          end else begin
            total <= div_neg ? (~quo + 32'd1) : quo;
          end
        end
        U_SHOW: begin
          entry <= total;
          pend  <= is_eq ? PEND_NONE : pend_t'({1'b0, opc} + 3'd1);
          fresh <= 1'b1;
        end
        U_NEGATE:  entry <= ~entry + 32'd1;
        U_LEN_END: chars <= {1'b0, len_k} + {4'd0, entry[31]};
        U_CLEAR: begin
          entry <= 32'd0;
          chars <= 5'd1;
          total <= 32'd0;
          pend  <= PEND_NONE;
          fresh <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // work registers, no reset
  always_ff @(posedge clk) begin
    case (word.op)
      U_DISPATCH: begin
        if (req.valid) begin
          dig   <= req.digit_value;
          opc   <= req.operator_code;
          is_eq <= (req.action == ACT_EQUALS);
        end
      end
      U_MUL10, U_MUL: prod <= mul_res;
      U_DIV_INIT: begin
        rem     <= 32'd0;
        quo     <= mag32(total);
        dvs     <= mag32(entry);
        div_neg <= total[31] ^ entry[31];
        div_cnt <= DivSteps;
      end
      U_DIV_STEP: begin
        // restoring step: keep the difference when it does not go negative
        if (!div_diff[32]) begin
          rem <= div_diff[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= div_shift[31:0];
          quo <= {quo[30:0], 1'b0};
        end
        div_cnt <= div_cnt - 6'd1;
      end
      U_LEN_INIT: begin
        len_mag <= mag32(entry);
        len_k   <= 4'd1;
      end
      U_LEN_STEP: begin
        if (len_more) begin
          len_k <= len_k + 4'd1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (word.op == U_EMIT && !out_busy) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (word.op == U_EMIT && !out_busy) begin
      out_value <= entry;
      out_chars <= chars;
      out_pend  <= pend;
      out_fresh <= fresh;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.shown_value      = out_value;
  assign rsp.shown_chars      = out_chars;
  assign rsp.operator_pending = out_pend;
  assign rsp.entry_is_fresh   = out_fresh;

  `FFC_ASSERT_NOW(a_upc_in_program, 1'b1, upc <= A_LAST, "sequencer left the control store")
  `FFC_ASSERT_NEXT(a_request_starts_routine, req.valid && req.ready, upc != A_IDLE,
                   "accepted request did not start a routine")
  `FFC_ASSERT_NOW(a_div_count_live, upc == A_DIV_LOOP, div_cnt != 6'd0,
                  "divider loop running with an empty step count")
  `FFC_ASSERT_NOW(a_result_chars_range, rsp.valid,
                  rsp.shown_chars != 5'd0 && rsp.shown_chars <= 5'd16,
                  "result character count out of range")

endmodule

`default_nettype wire

### bench/tb_four_function_calculator_core.sv
// ----------------------------------------------------------------------------
// tb_four_function_calculator_core
// self-checking bench for the keypad logic of the 32-bit integer calculator:
// a directed key sequence covers digit limits, wrap and the arithmetic corner
// cases, then random key sequences run under four sender/receiver idle mixes,
// and every display result is compared with a cycle-free software predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_four_function_calculator_core;
  import ffc_pkg::*;

  localparam int MaxChars    = 16;
  localparam int RandomKeys  = 2000;
  localparam int DrainCycles = 80;

  // operator codes on the request
  localparam logic [1:0] OpAdd = 2'd0;
  localparam logic [1:0] OpSub = 2'd1;
  localparam logic [1:0] OpMul = 2'd2;
  localparam logic [1:0] OpDiv = 2'd3;

  // action codes with no routine behind them
  localparam logic [2:0] FirstUnusedAction = 3'd5;
  localparam logic [2:0] LastUnusedAction  = 3'd7;

  typedef struct {
    logic [2:0] action;
    logic [3:0] digit;
    logic [1:0] opc;
    int         phase;
  } key_t;

  typedef struct {
    logic [31:0] value;
    logic [4:0]  chars;
    logic [2:0]  pend;
    logic        fresh;
  } display_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ffc_req_if req_ch ();
  ffc_rsp_if rsp_ch ();

  four_function_calculator_core #(
    .MAX_CHARS(MaxChars)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #10 clk = ~clk;

  key_t     pending_keys[$];
  display_t expected_displays[$];

  // predicted calculator state
  logic [31:0] calc_entry;
  logic [4:0]  calc_chars;
  logic [31:0] calc_total;
  pend_t       calc_pend;
  logic        calc_fresh;

  int mismatches       = 0;
  int keys_queued      = 0;
  int keys_taken       = 0;
  int displays_checked = 0;
  int idle_phase       = 0;
  bit req_taken        = 1'b0;

  function automatic int sender_idle_pct(input int ph);
    case (ph)
      1:       return 65;
      3:       return 19;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct(input int ph);
    case (ph)
      2:       return 65;
      3:       return 19;
      default: return 0;
    endcase
  endfunction

  function automatic logic [31:0] magnitude(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [4:0] digit_count(input logic [31:0] v);
    logic [31:0] m;
    logic [4:0]  n;
    m = magnitude(v);
    n = 5'd1;
    while (m >= 32'd10) begin
      m = m / 32'd10;
      n = n + 5'd1;
    end
    if (v[31]) n = n + 5'd1;
    return n;
  endfunction

  function automatic logic [31:0] combine(input logic [31:0] a, input pend_t op,
                                          input logic [31:0] b);
    logic [31:0] q;
    case (op)
      PEND_ADD: return a + b;
      PEND_SUB: return a - b;
      PEND_MUL: return a * b;
      PEND_DIV: begin
        if (b == 32'd0) return 32'd0;
        q = magnitude(a) / magnitude(b);
        if (a[31] ^ b[31]) q = 32'd0 - q;
        return q;
      end
      default: return b;
    endcase
  endfunction

  task automatic clear_calc();
    calc_entry = 32'd0;
    calc_chars = 5'd1;
    calc_total = 32'd0;
    calc_pend  = PEND_NONE;
    calc_fresh = 1'b1;
  endtask

  task automatic show_value(input logic [31:0] v);
    calc_entry = v;
    calc_chars = digit_count(v);
  endtask

  // advance the predicted state by one key and queue the display it yields
  task automatic predict_display(input logic [2:0] action, input logic [3:0] dig,
                                 input logic [1:0] opc);
    display_t d;
    case (action)
      ACT_DIGIT: begin
        if (dig <= 4'd9) begin
          if (calc_fresh || (calc_chars == 5'd1 && calc_entry == 32'd0)) begin
            calc_entry = {28'd0, dig};
            calc_chars = 5'd1;
            calc_fresh = 1'b0;
          end else if (calc_chars < MaxChars) begin
            // negative entries grow in magnitude
            if (calc_entry[31]) calc_entry = calc_entry * 32'd10 - {28'd0, dig};
            else calc_entry = calc_entry * 32'd10 + {28'd0, dig};
            calc_chars = calc_chars + 5'd1;
          end
        end
      end
      ACT_OPER: begin
        if (calc_pend != PEND_NONE && !calc_fresh)
          calc_total = combine(calc_total, calc_pend, calc_entry);
        else
          calc_total = calc_entry;
        show_value(calc_total);
        calc_pend  = pend_t'({1'b0, opc} + 3'd1);
        calc_fresh = 1'b1;
      end
      ACT_EQUALS: begin
        if (calc_pend != PEND_NONE) begin
          calc_total = combine(calc_total, calc_pend, calc_entry);
          show_value(calc_total);
          calc_pend  = PEND_NONE;
          calc_fresh = 1'b1;
        end
      end
      ACT_NEGATE: show_value(32'd0 - calc_entry);
      ACT_CLEAR:  clear_calc();
      default: ;
    endcase
    d.value = calc_entry;
    d.chars = calc_chars;
    d.pend  = calc_pend;
    d.fresh = calc_fresh;
    expected_displays.push_back(d);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t mismatch on %s: got %0d (0x%08h) expected %0d (0x%08h)",
             $realtime, what, $signed(got), got, $signed(want), want);
  endtask

  task automatic add_key(input logic [2:0] action, input logic [3:0] dig,
                         input logic [1:0] opc, input int ph);
    key_t k;
    k.action = action;
    k.digit  = dig;
    k.opc    = opc;
    k.phase  = ph;
    pending_keys.push_back(k);
    // ignored keys do not count toward the random budget
    if (action <= ACT_CLEAR && !(action == ACT_DIGIT && dig > 4'd9)) keys_queued++;
  endtask

  task automatic enter_number(input int ndigits, input int ph);
    for (int i = 0; i < ndigits; i++)
      add_key(ACT_DIGIT, 4'($urandom_range(9)), 2'($urandom_range(3)), ph);
  endtask

  // request driver, changes at the falling edge
  always @(negedge clk) begin
    key_t k;
    if (rst) begin
      req_ch.valid <= 1'b0;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (!req_ch.valid || req_taken) begin
        req_taken = 1'b0;
        // the sender stays idle this cycle with the phase's probability
        if (pending_keys.size() > 0 &&
            $urandom_range(99) >= sender_idle_pct(pending_keys[0].phase)) begin
          k = pending_keys.pop_front();
          idle_phase = k.phase;
          req_ch.valid         <= 1'b1;
          req_ch.action        <= k.action;
          req_ch.digit_value   <= k.digit;
          req_ch.operator_code <= k.opc;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct(idle_phase));
    end
  end

  // acceptance and result check, at the rising edge
  always @(posedge clk) begin
    display_t want;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        predict_display(req_ch.action, req_ch.digit_value, req_ch.operator_code);
        keys_taken++;
        req_taken = 1'b1;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_displays.size() == 0) begin
          report_mismatch("unexpected result", rsp_ch.shown_value, 32'd0);
        end else begin
          want = expected_displays.pop_front();
          if (rsp_ch.shown_value !== want.value)
            report_mismatch("shown_value", rsp_ch.shown_value, want.value);
          if (rsp_ch.shown_chars !== want.chars)
            report_mismatch("shown_chars", {27'd0, rsp_ch.shown_chars}, {27'd0, want.chars});
          if (rsp_ch.operator_pending !== want.pend)
            report_mismatch("operator_pending", {29'd0, rsp_ch.operator_pending},
                            {29'd0, want.pend});
          if (rsp_ch.entry_is_fresh !== want.fresh)
            report_mismatch("entry_is_fresh", {31'd0, rsp_ch.entry_is_fresh},
                            {31'd0, want.fresh});
          displays_checked++;
        end
      end
    end
  end

  initial begin
    int directed;
    int ph;
    int r;
    req_ch.valid         = 1'b0;
    req_ch.action        = ACT_CLEAR;
    req_ch.digit_value   = 4'd0;
    req_ch.operator_code = OpAdd;
    rsp_ch.ready         = 1'b0;
    clear_calc();

    // directed: leading zeros, ignored digits, most negative value and its
    // negation, most negative over minus one, division by zero, idle equals
    add_key(ACT_CLEAR, 4'd0, OpAdd, 0);
    add_key(ACT_DIGIT, 4'd0, OpAdd, 0);
    add_key(ACT_DIGIT, 4'd0, OpAdd, 0);
    add_key(ACT_DIGIT, 4'd15, OpDiv, 0);
    add_key(ACT_DIGIT, 4'd10, OpAdd, 0);
    add_key(ACT_DIGIT, 4'd2, OpAdd, 0);
    add_key(ACT_DIGIT, 4'd1, OpAdd, 0);
    add_key(ACT_DIGIT, 4'd4, OpAdd, 0);
    add_key(ACT_DIGIT, 4'd7, OpAdd, 0);
    add_key(ACT_DIGIT, 4'd4, OpAdd, 0);
    add_key(ACT_DIGIT, 4'd8, OpAdd, 0);
    add_key(ACT_DIGIT, 4'd3, OpAdd, 0);
    add_key(ACT_DIGIT, 4'd6, OpAdd, 0);
    add_key(ACT_DIGIT, 4'd4, OpAdd, 0);
    add_key(ACT_DIGIT, 4'd7, OpAdd, 0);
    add_key(ACT_OPER, 4'd0, OpAdd, 0);
    add_key(ACT_DIGIT, 4'd1, OpAdd, 0);
    add_key(ACT_EQUALS, 4'd0, OpAdd, 0);
    add_key(ACT_NEGATE, 4'd0, OpAdd, 0);
    add_key(ACT_OPER, 4'd0, OpDiv, 0);
    add_key(ACT_DIGIT, 4'd1, OpAdd, 0);
    add_key(ACT_NEGATE, 4'd0, OpAdd, 0);
    add_key(ACT_EQUALS, 4'd0, OpAdd, 0);
    add_key(ACT_OPER, 4'd9, OpDiv, 0);
    add_key(ACT_DIGIT, 4'd0, OpAdd, 0);
    add_key(ACT_EQUALS, 4'd0, OpAdd, 0);
    add_key(ACT_EQUALS, 4'd0, OpAdd, 0);
    add_key(ACT_OPER, 4'd0, OpSub, 0);
    add_key(ACT_OPER, 4'd0, OpMul, 0);
    for (logic [3:0] u = {1'b0, FirstUnusedAction}; u <= {1'b0, LastUnusedAction}; u++)
      add_key(u[2:0], 4'd5, OpMul, 0);
    add_key(ACT_CLEAR, 4'd0, OpAdd, 0);
    directed = keys_queued;

    // random: mostly well-formed entries with chained operators, plus noise
    while (keys_queued < directed + RandomKeys) begin
      ph = ((keys_queued - directed) * 4) / RandomKeys;
      if (ph > 3) ph = 3;
      r = $urandom_range(99);
      if (r < 80) begin
        if ($urandom_range(9) == 0) enter_number($urandom_range(18, 7), ph);
        else enter_number($urandom_range(6, 1), ph);
        if ($urandom_range(4) == 0) add_key(ACT_NEGATE, 4'd0, OpAdd, ph);
        if ($urandom_range(9) < 7)
          add_key(ACT_OPER, 4'($urandom_range(15)), 2'($urandom_range(3)), ph);
        else
          add_key(ACT_EQUALS, 4'($urandom_range(15)), 2'($urandom_range(3)), ph);
      end else if (r < 83) begin
        add_key(ACT_CLEAR, 4'($urandom_range(15)), 2'($urandom_range(3)), ph);
      end else begin
        add_key(3'($urandom_range(7)), 4'($urandom_range(15)), 2'($urandom_range(3)), ph);
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending_keys.size() > 0 || req_ch.valid) @(posedge clk);
    while (expected_displays.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("run covered %0d key requests and %0d checked display results,", keys_taken,
             displays_checked);
    $display("under no idling, sender gaps, receiver stalls and both mixed");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
